// ===== sv/iee_pkg.sv =====
`timescale 1ns / 1ps

package iee_pkg;

	localparam int CHAR_W     = 8;
	localparam int OUT_VALUE_W = 32;
	localparam int STATUS_W   = 2;
	localparam int OUT_DATA_W = 40;

	// character classes
	localparam logic [2:0] CL_DIGIT = 3'd0;
	localparam logic [2:0] CL_SPACE = 3'd1;
	localparam logic [2:0] CL_ADD   = 3'd2;
	localparam logic [2:0] CL_SUB   = 3'd3;
	localparam logic [2:0] CL_MUL   = 3'd4;
	localparam logic [2:0] CL_DIV   = 3'd5;
	localparam logic [2:0] CL_BAD   = 3'd6;

	// pending term operation
	localparam logic [1:0] TERM_START = 2'd0;
	localparam logic [1:0] TERM_MUL   = 2'd1;
	localparam logic [1:0] TERM_DIV   = 2'd2;

	// status codes
	localparam logic [1:0] ERR_OK      = 2'd0;
	localparam logic [1:0] ERR_DIV0    = 2'd1;
	localparam logic [1:0] ERR_BADCHAR = 2'd2;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic       num_load;
		logic       note_bad;
		logic       close_simple;
		logic       unit_start;
		logic       unit_write;
		logic       close_term;
		logic       set_sign;
		logic       sign_val;
		logic       set_op;
		logic [1:0] op_val;
		logic       emit;
	} dp_cmd_t;

	typedef struct packed {
		logic iter_need;
		logic unit_done;
	} dp_sts_t;

	function automatic logic [2:0] classify(input logic [CHAR_W-1:0] c);
		logic [2:0] cl;
		if (c >= CH_ZERO && c <= CH_NINE) cl = CL_DIGIT;
		else if (c == CH_SPACE) cl = CL_SPACE;
		else if (c == CH_PLUS) cl = CL_ADD;
		else if (c == CH_MINUS) cl = CL_SUB;
		else if (c == CH_STAR) cl = CL_MUL;
		else if (c == CH_SLASH) cl = CL_DIV;
		else cl = CL_BAD;
		return cl;
	endfunction

endpackage

// ===== sv/iee_muldiv.sv =====
`timescale 1ns / 1ps

module iee_muldiv #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   div,
	input  logic [VALUE_WIDTH-1:0] a,
	input  logic [VALUE_WIDTH-1:0] b,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] result
);

	localparam int W  = VALUE_WIDTH;
	localparam int CW = $clog2(W);

	logic          busy_q, done_q, mode_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q, opa_q, opb_q;
	logic [W:0]    trial;
	logic [W:0]    trial_sub;

	assign trial     = {acc_q, opb_q[W-1]};
	assign trial_sub = trial - {1'b0, opa_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) busy_q <= 1'b0;
				else cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= div;
			acc_q  <= '0;
			neg_q  <= a[W-1] ^ b[W-1];
			if (div) begin
				// work on magnitudes, fix the sign at the end
				opa_q <= b[W-1] ? (~b + 1'b1) : b;
				opb_q <= a[W-1] ? (~a + 1'b1) : a;
			end else begin
				opa_q <= a;
				opb_q <= b;
			end
		end else if (busy_q) begin
			if (mode_q) begin
				if (!trial_sub[W]) begin
					acc_q <= trial_sub[W-1:0];
					opb_q <= {opb_q[W-2:0], 1'b1};
				end else begin
					acc_q <= trial[W-1:0];
					opb_q <= {opb_q[W-2:0], 1'b0};
				end
			end else begin
				if (opb_q[0]) acc_q <= acc_q + opa_q;
				opa_q <= {opa_q[W-2:0], 1'b0};
				opb_q <= {1'b0, opb_q[W-1:1]};
			end
		end
	end

	assign done   = done_q;
	assign result = mode_q ? (neg_q ? (~opb_q + 1'b1) : opb_q) : acc_q;

endmodule

// ===== sv/iee_dp.sv =====
`timescale 1ns / 1ps

module iee_dp #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [iee_pkg::CHAR_W-1:0]          char_code,
	input  iee_pkg::dp_cmd_t                    cmd,
	output iee_pkg::dp_sts_t                    sts,
	output logic [iee_pkg::OUT_VALUE_W-1:0]     value,
	output logic [iee_pkg::STATUS_W-1:0]        status
);

	import iee_pkg::*;

	localparam int W     = VALUE_WIDTH;
	localparam int EXT_W = (W > OUT_VALUE_W) ? W : OUT_VALUE_W;

	logic [W-1:0]        cur_q, term_q, sum_q;
	logic                sign_q;
	logic [1:0]          op_q;
	logic [1:0]          err_q;
	logic [W-1:0]        cur_next, sum_next, unit_result;
	logic [3:0]          digit;
	logic                unit_done;
	logic signed [EXT_W-1:0] sum_ext;
	logic [OUT_VALUE_W-1:0]  value_q;
	logic [STATUS_W-1:0]     status_q;

	assign digit    = 4'(char_code - CH_ZERO);
	assign cur_next = (cur_q << 3) + (cur_q << 1) + W'(digit);
	assign sum_next = sign_q ? (sum_q - term_q) : (sum_q + term_q);
	assign sum_ext  = EXT_W'($signed(sum_q));

	iee_muldiv #(.VALUE_WIDTH(W)) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.unit_start),
		.div    (op_q == TERM_DIV),
		.a      (term_q),
		.b      (cur_q),
		.done   (unit_done),
		.result (unit_result)
	);

	assign sts.iter_need = (op_q == TERM_MUL) || ((op_q == TERM_DIV) && (cur_q != '0));
	assign sts.unit_done = unit_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			term_q <= '0;
			sum_q  <= '0;
			sign_q <= 1'b0;
			op_q   <= TERM_START;
			err_q  <= ERR_OK;
		end else if (cmd.emit) begin
			// result taken: back to a fresh expression
			cur_q  <= '0;
			term_q <= '0;
			sum_q  <= '0;
			sign_q <= 1'b0;
			op_q   <= TERM_START;
			err_q  <= ERR_OK;
		end else begin
			if (cmd.num_load) cur_q <= cur_next;
			if (cmd.note_bad && err_q == ERR_OK) err_q <= ERR_BADCHAR;
			if (cmd.close_simple) begin
				cur_q <= '0;
				if (op_q == TERM_DIV) begin
					term_q <= '0;
					if (err_q == ERR_OK) err_q <= ERR_DIV0;
				end else begin
					term_q <= cur_q;
				end
			end
			if (cmd.unit_write) begin
				term_q <= unit_result;
				cur_q  <= '0;
			end
			if (cmd.close_term) begin
				sum_q  <= sum_next;
				term_q <= '0;
				op_q   <= TERM_START;
			end
			if (cmd.set_sign) sign_q <= cmd.sign_val;
			if (cmd.set_op) op_q <= cmd.op_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			value_q  <= (err_q == ERR_OK) ? sum_ext[OUT_VALUE_W-1:0] : '0;
			status_q <= err_q;
		end
	end

	assign value  = value_q;
	assign status = status_q;

endmodule

// ===== sv/iee_ctrl.sv =====
`timescale 1ns / 1ps

module iee_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [iee_pkg::CHAR_W-1:0] in_char,
	input  logic                       in_last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output iee_pkg::dp_cmd_t           cmd,
	input  iee_pkg::dp_sts_t           sts
);

	import iee_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_OPND = 3'd1;
	localparam logic [2:0] ST_ITER = 3'd2;
	localparam logic [2:0] ST_TERM = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q, state_d;
	logic [2:0] kind_q;
	logic       last_q, final_q, final_d;
	logic       out_valid_q;
	logic [2:0] cls;
	logic       is_op;
	logic       accept;

	assign cls    = classify(in_char);
	assign is_op  = (cls == CL_ADD) || (cls == CL_SUB) || (cls == CL_MUL) || (cls == CL_DIV);
	assign accept = in_valid && (state_q == ST_IDLE);

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		final_d  = final_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (cls == CL_DIGIT) cmd.num_load = 1'b1;
					if (cls == CL_BAD) cmd.note_bad = 1'b1;
					if (is_op) begin
						state_d = ST_OPND;
						final_d = 1'b0;
					end else if (in_last) begin
						state_d = ST_OPND;
						final_d = 1'b1;
					end
				end
			end
			ST_OPND: begin
				if (sts.iter_need) begin
					cmd.unit_start = 1'b1;
					state_d = ST_ITER;
				end else begin
					cmd.close_simple = 1'b1;
					state_d = ST_TERM;
				end
			end
			ST_ITER: begin
				if (sts.unit_done) begin
					cmd.unit_write = 1'b1;
					state_d = ST_TERM;
				end
			end
			ST_TERM: begin
				if (final_q) begin
					cmd.close_term = 1'b1;
					state_d = ST_EMIT;
				end else begin
					priority case (kind_q)
						CL_ADD, CL_SUB: begin
							cmd.close_term = 1'b1;
							cmd.set_sign = 1'b1;
							cmd.sign_val = (kind_q == CL_SUB);
						end
						CL_MUL: begin
							cmd.set_op = 1'b1;
							cmd.op_val = TERM_MUL;
						end
						default: begin
							cmd.set_op = 1'b1;
							cmd.op_val = TERM_DIV;
						end
					endcase
					// an operator marked last still closes the expression
					if (last_q) begin
						final_d = 1'b1;
						state_d = ST_OPND;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= CL_SPACE;
			last_q      <= 1'b0;
			final_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			final_q <= final_d;
			if (accept) begin
				kind_q <= cls;
				last_q <= in_last;
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/infix_expression_evaluator_core.sv =====
`timescale 1ns / 1ps

// Evaluates an infix expression of unsigned decimal operands and + - * /, one
// character per input beat, with tlast marking the final character. Multiply
// and divide bind tighter than add and subtract; division truncates toward zero;
// all arithmetic wraps at VALUE_WIDTH bits. After the last character one output
// beat carries the value (sign-extended or cut to 32 bits, zero on error) and a
// status: 0 ok, 1 divide by zero, 2 bad character. Digits, spaces and bad
// characters are taken in the idle state. An operator passes the operand and
// term states, and also the iterate state when it closes a multiply or a divide
// by a nonzero operand, since one shared shift-add / restoring divide unit
// handles one bit per cycle. The last character then closes the pending operand
// (once more when it is itself an operator) and the emit state registers the result beat.
// A finished result waits in the output register while new characters are taken.
module infix_expression_evaluator_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [iee_pkg::CHAR_W-1:0]         s_axis_tdata,  // [7:0] char_code
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [iee_pkg::OUT_DATA_W-1:0]     m_axis_tdata   // [31:0] value, [33:32] status
);

	import iee_pkg::*;

	dp_cmd_t                cmd;
	dp_sts_t                sts;
	logic [OUT_VALUE_W-1:0] value;
	logic [STATUS_W-1:0]    status;

	iee_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_char   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	iee_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value),
		.status    (status)
	);

	assign m_axis_tdata = {(OUT_DATA_W - OUT_VALUE_W - STATUS_W)'(0), status, value};

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import iee_pkg::*;

	localparam int ITEM_TARGET  = 900;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 500000;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} char_beat_t;

	typedef struct {
		logic [OUT_VALUE_W-1:0] value;
		logic [STATUS_W-1:0]    status;
	} expr_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [CHAR_W-1:0]     s_axis_tdata = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	char_beat_t   pending_chars[$];
	expr_result_t expected_results[$];
	char_beat_t   next_char;
	expr_result_t got_result;
	expr_result_t want_result;

	// evaluator state mirrored at 32 bits
	logic [31:0]         sum_acc;
	logic [31:0]         term_acc;
	logic [31:0]         operand_acc;
	logic                minus_pending;
	logic [1:0]          term_op;
	logic [STATUS_W-1:0] first_error;

	int  mismatch_count = 0;
	int  cycle_count = 0;
	int  send_wait = 0;
	int  recv_wait = 0;
	bit  quiet_send = 1'b0;
	bit  quiet_recv = 1'b0;

	infix_expression_evaluator_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] trunc_quotient(logic [31:0] n, logic [31:0] d);
		logic [31:0] n_mag;
		logic [31:0] d_mag;
		logic [31:0] q;
		n_mag = n[31] ? -n : n;
		d_mag = d[31] ? -d : d;
		q = n_mag / d_mag;
		return (n[31] ^ d[31]) ? -q : q;
	endfunction

	task automatic clear_evaluator();
		sum_acc = '0;
		term_acc = '0;
		operand_acc = '0;
		minus_pending = 1'b0;
		term_op = TERM_START;
		first_error = ERR_OK;
	endtask

	task automatic note_error(logic [STATUS_W-1:0] code);
		if (first_error == ERR_OK)
			first_error = code;
	endtask

	task automatic fold_operand();
		case (term_op)
			TERM_MUL: term_acc = term_acc * operand_acc;
			TERM_DIV: begin
				if (operand_acc == 0) begin
					note_error(ERR_DIV0);
					term_acc = '0;
				end else begin
					term_acc = trunc_quotient(term_acc, operand_acc);
				end
			end
			default: term_acc = operand_acc;
		endcase
		operand_acc = '0;
	endtask

	task automatic fold_term();
		sum_acc = minus_pending ? sum_acc - term_acc : sum_acc + term_acc;
		term_acc = '0;
		term_op = TERM_START;
	endtask

	task automatic absorb_char(logic [CHAR_W-1:0] ch, logic last);
		expr_result_t r;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			operand_acc = operand_acc * 10 + 32'(ch - CH_ZERO);
		end else if (ch == CH_PLUS || ch == CH_MINUS) begin
			fold_operand();
			fold_term();
			minus_pending = (ch == CH_MINUS);
		end else if (ch == CH_STAR || ch == CH_SLASH) begin
			fold_operand();
			term_op = (ch == CH_STAR) ? TERM_MUL : TERM_DIV;
		end else if (ch != CH_SPACE) begin
			note_error(ERR_BADCHAR);
		end
		if (last) begin
			fold_operand();
			fold_term();
			r.value = (first_error == ERR_OK) ? sum_acc : '0;
			r.status = first_error;
			expected_results.push_back(r);
			clear_evaluator();
		end
	endtask

	task automatic add_byte(logic [CHAR_W-1:0] ch, logic last);
		char_beat_t b;
		b.ch = ch;
		b.last = last;
		pending_chars.push_back(b);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i], 1'b0);
		pending_chars[pending_chars.size()-1].last = 1'b1;
	endtask

	function automatic logic [CHAR_W-1:0] operator_char(int sel);
		case (sel)
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	// scatter spaces and the odd stray byte through the digits
	task automatic add_digits(string s);
		for (int i = 0; i < s.len(); i++) begin
			if ($urandom_range(0, 7) == 0)
				add_byte(CH_SPACE, 1'b0);
			if ($urandom_range(0, 47) == 0)
				add_byte(8'($urandom_range(0, 255)), 1'b0);
			add_byte(s[i], 1'b0);
		end
	endtask

	task automatic add_operand();
		string digits;
		digits = "";
		case ($urandom_range(0, 9))
			0: digits = "";
			1: digits = "0";
			2, 3, 4, 5: digits = $sformatf("%0d", $urandom_range(1, 99));
			6: digits = $sformatf("%0d", $urandom());
			7: digits = "4294967295";
			8: digits = "2147483648";
			default: begin
				repeat ($urandom_range(10, 12))
					digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
			end
		endcase
		add_digits(digits);
	endtask

	task automatic add_expression();
		int n_operands;
		if ($urandom_range(0, 9) == 0) begin
			// garbage run
			repeat ($urandom_range(1, 6))
				add_byte(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			if ($urandom_range(0, 7) == 0)
				add_byte(operator_char($urandom_range(0, 3)), 1'b0);
			n_operands = $urandom_range(1, 5);
			for (int k = 0; k < n_operands; k++) begin
				if (k > 0)
					add_byte(operator_char($urandom_range(0, 3)), 1'b0);
				add_operand();
			end
			if ($urandom_range(0, 9) == 0)
				add_byte($urandom_range(0, 1) ? CH_SPACE : operator_char($urandom_range(0, 3)),
					1'b0);
		end
		if (pending_chars.size() == 0)
			add_byte(CH_SPACE, 1'b0);
		pending_chars[pending_chars.size()-1].last = 1'b1;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			clear_evaluator();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				absorb_char(s_axis_tdata, s_axis_tlast);
				if ($urandom_range(0, 63) == 0)
					quiet_send = !quiet_send;
				send_wait = quiet_send ? 0 : $urandom_range(0, 8);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_wait == 0 && pending_chars.size() != 0) begin
					next_char = pending_chars.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_char.ch;
					s_axis_tlast <= next_char.last;
				end else begin
					s_axis_tvalid <= 1'b0;
					if (send_wait > 0)
						send_wait--;
				end
			end
		end
	end

	// monitor: hold off ready for a drawn number of cycles once a result shows up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_result.value = m_axis_tdata[OUT_VALUE_W-1:0];
				got_result.status = m_axis_tdata[OUT_VALUE_W +: STATUS_W];
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, got value %h status %0d",
						$time, got_result.value, got_result.status);
					mismatch_count++;
				end else begin
					want_result = expected_results.pop_front();
					if (got_result.value !== want_result.value) begin
						$display("%0t: value mismatch: expected %h, got %h",
							$time, want_result.value, got_result.value);
						mismatch_count++;
					end
					if (got_result.status !== want_result.status) begin
						$display("%0t: status mismatch: expected %0d, got %0d",
							$time, want_result.status, got_result.status);
						mismatch_count++;
					end
				end
				if ($urandom_range(0, 15) == 0)
					quiet_recv = !quiet_recv;
				recv_wait = quiet_recv ? 0 : $urandom_range(0, 8);
			end else if (m_axis_tvalid && recv_wait > 0) begin
				recv_wait--;
			end
			m_axis_tready <= (recv_wait == 0);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("infix_expression_evaluator_core regression: fail");
			$finish;
		end
	end

	initial begin
		// leading minus with wrapped negative dividend
		add_text("-4294967289/2");
		add_text("7/0");
		add_text("9 9*8+");
		add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b1);
		// bad character first, divide by zero after: keep the first error
		add_text("a/0");
		while (pending_chars.size() < ITEM_TARGET)
			add_expression();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_chars.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_results.size() != 0) begin
			$display("%0t: missing results: expected %0d more, got none",
				$time, expected_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("infix_expression_evaluator_core regression: pass");
		else
			$display("infix_expression_evaluator_core regression: fail");
		$finish;
	end

endmodule

// ===== infix_expression_evaluator_core.f =====
sv/iee_pkg.sv
sv/iee_muldiv.sv
sv/iee_dp.sv
sv/iee_ctrl.sv
sv/infix_expression_evaluator_core.sv
bench/testbench.sv
